/* src/rebg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebg_pkg: shared types and codes for the rotary encoder gesture unit
// Transaction payloads, gesture codes, event codes and direction codes.
// ----------------------------------------------------------------------------
package rebg_pkg;

    // tick transaction payload
    typedef struct packed {
        logic enc_clk;
        logic enc_dt;
        logic switch_n;
        logic ack_rotation;
        logic ack_button;
    } in_t;

    // result transaction payload
    typedef struct packed {
        logic signed [1:0] direction;
        logic [1:0]        button_event;
    } out_t;

    localparam int CountW = 16;
    localparam int GestW  = 3;

    localparam logic [CountW-1:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [CountW-1:0] HOLD_TICKS_RESET = 16'd60;

    // gesture machine codes
    localparam logic [GestW-1:0] G_IDLE    = 3'd0;
    localparam logic [GestW-1:0] G_PRESSED = 3'd1;
    localparam logic [GestW-1:0] G_HELD    = 3'd2;
    localparam logic [GestW-1:0] G_CLICKED = 3'd3;
    localparam logic [GestW-1:0] G_DCLICK  = 3'd4;

    // button event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_CLICK  = 2'd1;
    localparam logic [1:0] EV_DCLICK = 2'd2;
    localparam logic [1:0] EV_HELD   = 2'd3;

    // direction codes
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_POS  = 2'sb01;
    localparam logic signed [1:0] DIR_NEG  = 2'sb11;

    // register map
    localparam logic REG_HOLD_TICKS = 1'b0;

    // next values from the gesture machine
    typedef struct packed {
        logic [GestW-1:0]  gesture;
        logic [1:0]        pending_event;
        logic [CountW-1:0] tick_count;
    } gest_upd_t;

endpackage

/* src/rebg_quad.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebg_quad: quadrature step decoder
// Turns the previous and current pin codes into the new direction.
// ----------------------------------------------------------------------------
module rebg_quad (
    input  logic [1:0]        prev_quad,
    input  logic [1:0]        code,
    input  logic signed [1:0] last_dir,
    output logic signed [1:0] dir_next
);
    import rebg_pkg::*;

    always_comb
    begin
        dir_next = last_dir;
        if ((prev_quad == 2'd0 && code == 2'd1) || (prev_quad == 2'd3 && code == 2'd2))
        begin
            dir_next = DIR_POS;
        end
        else if ((prev_quad == 2'd1 && code == 2'd0) || (prev_quad == 2'd2 && code == 2'd3))
        begin
            dir_next = DIR_NEG;
        end
    end

endmodule

/* src/rebg_gesture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebg_gesture: switch gesture machine
// Next gesture, pending event and tick count for one tick.
// ----------------------------------------------------------------------------
module rebg_gesture (
    input  logic [rebg_pkg::GestW-1:0]  gesture,
    input  logic [1:0]                  pending_event,
    input  logic [rebg_pkg::CountW-1:0] count_inc,
    input  logic [rebg_pkg::CountW-1:0] hold_ticks,
    input  logic                        pressed,
    output rebg_pkg::gest_upd_t         upd
);
    import rebg_pkg::*;

    logic timed;

    assign timed = (count_inc >= hold_ticks);

    always_comb
    begin
        upd.gesture       = gesture;
        upd.pending_event = pending_event;
        upd.tick_count    = count_inc;
        unique case (gesture)
            G_IDLE:
            begin
                if (pressed)
                begin
                    upd.tick_count = '0;
                    upd.gesture    = G_PRESSED;
                end
            end
            G_PRESSED:
            begin
                if (timed)
                begin
                    upd.gesture       = G_HELD;
                    upd.pending_event = EV_HELD;
                end
                else if (!pressed)
                begin
                    upd.gesture = G_CLICKED;
                end
            end
            G_HELD:
            begin
                if (!pressed)
                begin
                    upd.tick_count    = '0;
                    upd.gesture       = G_IDLE;
                    upd.pending_event = EV_NONE;
                end
            end
            G_CLICKED:
            begin
                // click event may be set in the same tick as a second press
                if (timed)
                begin
                    upd.gesture       = G_IDLE;
                    upd.pending_event = EV_CLICK;
                end
                if (pressed)
                begin
                    upd.gesture = G_DCLICK;
                end
            end
            G_DCLICK:
            begin
                upd.tick_count = '0;
                if (!pressed)
                begin
                    upd.gesture       = G_IDLE;
                    upd.pending_event = EV_DCLICK;
                end
            end
            default:
            begin
                upd.gesture = G_IDLE;
            end
        endcase
    end

endmodule

/* src/rotary_encoder_button_gestures_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_button_gestures_unit: rotary encoder and push switch gestures
// Per-tick quadrature direction and click / double click / hold detection.
// ----------------------------------------------------------------------------
// usage
//   in channel: one transaction per sample tick carrying the encoder clock and
//   data pins, the active-low switch pin and the two read acknowledges
//   out channel: one transaction per tick with the direction and the pending
//   button event as they stand after that tick
//   latency: the result is valid in the cycle after the tick is accepted
//   throughput: one tick per cycle unless a result waits with out_stall high;
//   the result register is the single register stage after the state logic
//   stall: while a result waits with out_stall high, in_stall is raised; the
//   held result stays put and no encoder or gesture state changes
//   reset: encoder code, direction, gesture, event and tick counter clear to
//   zero / idle, hold_ticks returns to 60, the result register empties
//   config: hold_ticks at byte address 0 over the APB port, written while idle
//   acknowledges act after the tick is reported: ack_rotation clears the
//   direction, ack_button clears the event unless it is held
// ----------------------------------------------------------------------------
module rotary_encoder_button_gestures_unit (
    input  logic                clk,
    input  logic                rst_n,
    // tick channel
    input  logic                in_valid,
    output logic                in_stall,
    input  rebg_pkg::in_t       in_data,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output rebg_pkg::out_t      out_data,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rebg_pkg::*;

    // state
    logic [CountW-1:0]  hold_ticks_reg;
    logic [1:0]         prev_quad_reg;
    logic signed [1:0]  last_dir_reg;
    logic [GestW-1:0]   gesture_reg;
    logic [1:0]         pending_event_reg;
    logic [CountW-1:0]  tick_count_reg;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    out_t               out_data_reg;

    logic               accept;
    logic               cfg_write;
    logic [1:0]         code;
    logic [CountW-1:0]  count_inc;
    logic signed [1:0]  dir_next;
    gest_upd_t          upd;
    out_t               result;

    // handshakes
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_HOLD_TICKS);
    assign prdata    = (paddr[2] == REG_HOLD_TICKS) ?
                       {{(32-CountW){1'b0}}, hold_ticks_reg} : 32'd0;

    // saturating counter steps first
    assign count_inc = (tick_count_reg != COUNT_MAX) ? tick_count_reg + 1'b1
                                                     : tick_count_reg;
    // data pin is bit 1, clock pin bit 0
    assign code = {in_data.enc_dt, in_data.enc_clk};

    rebg_quad u_quad (
        .prev_quad (prev_quad_reg),
        .code      (code),
        .last_dir  (last_dir_reg),
        .dir_next  (dir_next)
    );

    rebg_gesture u_gesture (
        .gesture       (gesture_reg),
        .pending_event (pending_event_reg),
        .count_inc     (count_inc),
        .hold_ticks    (hold_ticks_reg),
        .pressed       (!in_data.switch_n),
        .upd           (upd)
    );

    assign result.direction    = dir_next;
    assign result.button_event = upd.pending_event;

    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg    <= HOLD_TICKS_RESET;
            prev_quad_reg     <= 2'd0;
            last_dir_reg      <= DIR_NONE;
            gesture_reg       <= G_IDLE;
            pending_event_reg <= EV_NONE;
            tick_count_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                hold_ticks_reg <= pwdata[CountW-1:0];
            end
            if (accept)
            begin
                prev_quad_reg  <= code;
                gesture_reg    <= upd.gesture;
                tick_count_reg <= upd.tick_count;
                // acknowledges clear after the result is captured
                last_dir_reg   <= in_data.ack_rotation ? DIR_NONE : dir_next;
                if (in_data.ack_button && upd.pending_event != EV_HELD)
                begin
                    pending_event_reg <= EV_NONE;
                end
                else
                begin
                    pending_event_reg <= upd.pending_event;
                end
            end
        end
    end

    // payload register, loads on each accepted tick
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

endmodule

/* src/rebg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebg_checker: port-level checks for the gesture unit
// Watches the tick and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rebg_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  rebg_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  rebg_pkg::out_t out_data
);
    import rebg_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // input is held off exactly while a result waits
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow the waiting result");

    // every accepted tick produces a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted tick gave no result");

    // direction is never the unused code
    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.direction == DIR_NONE || out_data.direction == DIR_POS ||
                       out_data.direction == DIR_NEG))
        else $error("illegal direction code");

endmodule

bind rotary_encoder_button_gestures_unit rebg_checker u_rebg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* test/tb_rotary_encoder_button_gestures_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_encoder_button_gestures_unit: self-checking bench for the gesture unit
// Drives sample ticks through the valid/stall channel, predicts direction and
// button event for every tick and compares each result transaction in order.
// A short table covers the encoder transitions and every gesture, then random
// switch runs and encoder walks go through several hold_ticks settings.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_button_gestures_unit;
    import rebg_pkg::*;

    // run limit in clock cycles, well above the slowest legal run
    localparam int LIMIT      = 600000;
    // cycles the result side holds off in the back-pressure phase
    localparam int HOG_CYCLES = 200;
    localparam int N_DIRECTED = 28;
    localparam int N_PHASES   = 6;
    localparam int PHASE_LEN  = 110;

    // byte address of hold_ticks on the configuration port
    localparam logic [2:0] HOLD_ADDR = {REG_HOLD_TICKS, 2'b00};

    // encoder pin code {dt, clk}
    localparam logic [1:0] PINS_LOW   = 2'b00;
    localparam logic [1:0] PINS_CLK   = 2'b01;
    localparam logic [1:0] PINS_DT    = 2'b10;
    localparam logic [1:0] PINS_HIGH  = 2'b11;

    // one line of the directed table: either a hold_ticks write or a tick
    // repeated reps times, optionally with the result written out by hand
    typedef struct packed {
        logic        cfg;
        logic [15:0] hold;
        in_t         tick;
        int          reps;
        logic        typed;
        out_t        want;
    } row_t;

    // tick bits: clk dt switch_n ack_rotation ack_button
    localparam row_t DIRECTED [N_DIRECTED] = '{
        // right after reset: nothing moved, nothing pressed
        '{1'b0, 16'd0,     5'b00100, 1,     1'b1, '{DIR_NONE, EV_NONE}},
        '{1'b1, 16'd3,     5'b00000, 0,     1'b0, '{DIR_NONE, EV_NONE}},
        // full encoder cycle: 0->1 up, 1->3 neutral, 3->2 up, 2->3 down
        '{1'b0, 16'd0,     5'b10100, 1,     1'b1, '{DIR_POS, EV_NONE}},
        '{1'b0, 16'd0,     5'b11100, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b01100, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b11100, 1,     1'b1, '{DIR_NEG, EV_NONE}},
        // rotation acknowledge after reporting, then 1->0 down
        '{1'b0, 16'd0,     5'b10110, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00110, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        // encoder jump 0->2 leaves the cleared direction alone
        '{1'b0, 16'd0,     5'b01100, 1,     1'b1, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00100, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        // single click, window counted from the press
        '{1'b0, 16'd0,     5'b00000, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00100, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00100, 3,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00101, 1,     1'b1, '{DIR_NONE, EV_CLICK}},
        // double click
        '{1'b0, 16'd0,     5'b00000, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00100, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00000, 2,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00101, 1,     1'b1, '{DIR_NONE, EV_DCLICK}},
        // hold: the button acknowledge must not clear it
        '{1'b0, 16'd0,     5'b00001, 5,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00001, 1,     1'b1, '{DIR_NONE, EV_HELD}},
        '{1'b0, 16'd0,     5'b00100, 1,     1'b1, '{DIR_NONE, EV_NONE}},
        // zero hold time: every compare is true
        '{1'b1, 16'd0,     5'b00000, 0,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00000, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00100, 1,     1'b1, '{DIR_NONE, EV_HELD}},
        '{1'b0, 16'd0,     5'b00100, 1,     1'b0, '{DIR_NONE, EV_NONE}},
        // longest hold time: a short press stays a plain press
        '{1'b1, 16'd65535, 5'b00000, 0,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b00000, 3,     1'b0, '{DIR_NONE, EV_NONE}},
        '{1'b0, 16'd0,     5'b10100, 1,     1'b1, '{DIR_POS, EV_NONE}}
    };

    // hold_ticks for each random phase
    localparam logic [15:0] PHASE_HOLD [N_PHASES] = '{
        16'd1, 16'd4, 16'd60, 16'd2, 16'd0, 16'd7
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predicted direction/event per accepted tick, oldest first
    out_t predicted_results [$];
    int   errors = 0;
    int   cycles = 0;

    // idling control shared by both sides
    logic quiet   = 1'b0;
    logic hog_req = 1'b0;

    // predictor state
    logic [1:0]        quad_q  = PINS_LOW;
    logic signed [1:0] dir_q   = DIR_NONE;
    logic [GestW-1:0]  gest_q  = G_IDLE;
    logic [1:0]        event_q = EV_NONE;
    logic [CountW-1:0] ticks_q = '0;
    logic [CountW-1:0] hold_q  = HOLD_TICKS_RESET;

    // random stimulus state: switch level, ticks left at that level, pins
    logic       sw_level = 1'b1;
    int         sw_run   = 0;
    logic [1:0] enc_code = PINS_LOW;

    rotary_encoder_button_gestures_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop in case something hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_rotary_encoder_button_gestures_unit failed");
            $finish;
        end
    end

    // mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // one sample tick: counter, then encoder, then gesture machine; the
    // result shows the state before the acknowledges take effect
    function automatic out_t predict_tick(in_t t);
        logic [1:0] code;
        logic       pressed;
        logic       timed;
        out_t       r;
        code    = {t.enc_dt, t.enc_clk};
        pressed = !t.switch_n;

        if (ticks_q != COUNT_MAX)
            ticks_q = ticks_q + 1'b1;

        // only four of the eight neighbor steps set a direction, other changes just track
        if (code != quad_q)
        begin
            if ((quad_q == PINS_LOW && code == PINS_CLK) ||
                (quad_q == PINS_HIGH && code == PINS_DT))
                dir_q = DIR_POS;
            else if ((quad_q == PINS_CLK && code == PINS_LOW) ||
                     (quad_q == PINS_DT && code == PINS_HIGH))
                dir_q = DIR_NEG;
            quad_q = code;
        end

        timed = (ticks_q >= hold_q);
        case (gest_q)
            G_IDLE:
            begin
                if (pressed)
                begin
                    ticks_q = '0;
                    gest_q  = G_PRESSED;
                end
            end
            G_PRESSED:
            begin
                if (!pressed)
                    gest_q = G_CLICKED;
                // long enough wins over a release in the same tick
                if (timed)
                begin
                    gest_q  = G_HELD;
                    event_q = EV_HELD;
                end
            end
            G_HELD:
            begin
                if (!pressed)
                begin
                    ticks_q = '0;
                    gest_q  = G_IDLE;
                    event_q = EV_NONE;
                end
            end
            G_CLICKED:
            begin
                if (timed)
                begin
                    gest_q  = G_IDLE;
                    event_q = EV_CLICK;
                end
                // second press goes to double click, a fresh click stays
                if (pressed)
                    gest_q = G_DCLICK;
            end
            G_DCLICK:
            begin
                ticks_q = '0;
                if (!pressed)
                begin
                    gest_q  = G_IDLE;
                    event_q = EV_DCLICK;
                end
            end
            default:
                gest_q = G_IDLE;
        endcase

        r.direction    = dir_q;
        r.button_event = event_q;

        if (t.ack_rotation)
            dir_q = DIR_NONE;
        if (t.ack_button && event_q != EV_HELD)
            event_q = EV_NONE;
        return r;
    endfunction

    // switch runs sized around hold_ticks so clicks, double clicks and
    // holds all show up, with some single-tick chatter; encoder walks
    function automatic in_t random_tick();
        in_t t;
        int  r;
        if (sw_run == 0)
        begin
            sw_level = !sw_level;
            r = $urandom_range(0, 7);
            if (r == 0)
                sw_run = 1;
            else if (r < 6)
                sw_run = $urandom_range(1, hold_q + 2);
            else
                sw_run = $urandom_range(hold_q + 1, 2 * hold_q + 4);
        end
        sw_run = sw_run - 1;

        r = $urandom_range(0, 9);
        if (r < 6)
            enc_code = enc_code ^ ($urandom_range(0, 1) ? PINS_CLK : PINS_DT);
        else if (r == 6)
            enc_code = enc_code ^ PINS_HIGH;

        t.enc_clk      = enc_code[0];
        t.enc_dt       = enc_code[1];
        t.switch_n     = sw_level;
        t.ack_rotation = ($urandom_range(0, 3) == 0);
        t.ack_button   = ($urandom_range(0, 3) == 0);
        return t;
    endfunction

    // offer one tick, wait for it to be taken, record its prediction,
    // then maybe leave a gap before the next one
    task automatic send_tick(input in_t t, input logic typed, input out_t want);
        out_t p;
        int   gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = predict_tick(t);
        predicted_results.push_back(typed ? want : p);
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
    endtask

    // one setup + access transfer on the configuration port
    task automatic apb_xfer(input logic wr, input logic [31:0] wd,
                            output logic [31:0] rd);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= HOLD_ADDR;
        pwdata  <= wd;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write hold_ticks, mirror it in the predictor and read it back
    task automatic set_hold(input logic [15:0] v);
        logic [31:0] rd;
        apb_xfer(1'b1, {16'd0, v}, rd);
        hold_q = v;
        apb_xfer(1'b0, '0, rd);
        if (rd !== {16'd0, v})
        begin
            $display("%0t: hold_ticks readback mismatch, expected %0d, got %0d",
                     $time, v, rd);
            errors = errors + 1;
        end
    endtask

    // result side: random hold-offs, plus one long one on request
    initial
    begin
        int run;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hog_req)
            begin
                hog_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOG_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                run = quiet ? 0 : idle_len();
                if (run > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (run) @(negedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    // every result transaction against the oldest prediction
    always @(posedge clk)
    begin
        out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got dir %0d event %0d",
                         $time, $signed(out_data.direction), out_data.button_event);
                errors = errors + 1;
            end
            else
            begin
                e = predicted_results.pop_front();
                if (out_data.direction !== e.direction)
                begin
                    $display("%0t: direction mismatch, expected %0d, got %0d",
                             $time, $signed(e.direction), $signed(out_data.direction));
                    errors = errors + 1;
                end
                if (out_data.button_event !== e.button_event)
                begin
                    $display("%0t: button_event mismatch, expected %0d, got %0d",
                             $time, e.button_event, out_data.button_event);
                    errors = errors + 1;
                end
            end
        end
    end

    initial
    begin
        row_t        row;
        logic [31:0] rd;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // hold_ticks must come out of reset at its default
        apb_xfer(1'b0, '0, rd);
        if (rd !== {16'd0, HOLD_TICKS_RESET})
        begin
            $display("%0t: hold_ticks reset mismatch, expected %0d, got %0d",
                     $time, HOLD_TICKS_RESET, rd);
            errors = errors + 1;
        end

        // directed table; any long row runs without idling
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED[i];
            if (row.cfg)
            begin
                drain();
                set_hold(row.hold);
            end
            else
            begin
                quiet = (row.reps > 100);
                repeat (row.reps) send_tick(row.tick, row.typed, row.want);
                quiet = 1'b0;
            end
        end

        // random phases, each at its own hold time, each one drained first
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            set_hold(PHASE_HOLD[ph]);
            sw_run = 0;
            // phase 1: result side blocks while ticks keep coming
            if (ph == 1)
                hog_req = 1'b1;
            // phase 3: back-to-back on both sides
            quiet = (ph == 3);
            for (int n = 0; n < PHASE_LEN; n++)
                send_tick(random_tick(), 1'b0, '0);
            quiet = 1'b0;
        end

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("tb_rotary_encoder_button_gestures_unit passed");
        else
            $display("tb_rotary_encoder_button_gestures_unit failed");
        $finish;
    end

endmodule
